FILE: sv/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg: shared types and constants of the set-associative tag controller
// Address split, way count, PLRU victim and next-state tables, and the
// structs that pass between the lookup, line store and counter units.
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int NUM_SETS   = 16;
  localparam int LINE_BYTES = 8;
  localparam int ADDR_BITS  = 16;
  localparam int WAYS       = 4;
  localparam int CNT_W      = 32;

  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int IDX_W  = $clog2(NUM_SETS);
  localparam int TAG_W  = ADDR_BITS - OFF_W - IDX_W;
  localparam int WAY_W  = $clog2(WAYS);
  localparam int PLRU_W = 3;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [TAG_W-1:0]     tag_t;
  typedef logic [WAY_W-1:0]     way_t;
  typedef logic [PLRU_W-1:0]    plru_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [WAYS-1:0]      way_mask_t;
  typedef tag_t [WAYS-1:0]      tag_row_t;

  // Victim way named by each tree PLRU state.
  localparam way_t PLRU_VICTIM [2**PLRU_W] = '{
    2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
  };

  // Next PLRU state, indexed by {old state, way used}.
  localparam plru_t PLRU_NEXT [2**(PLRU_W+WAY_W)] = '{
    3'd6, 3'd4, 3'd1, 3'd0,
    3'd7, 3'd5, 3'd1, 3'd0,
    3'd6, 3'd4, 3'd3, 3'd2,
    3'd7, 3'd5, 3'd3, 3'd2,
    3'd6, 3'd4, 3'd1, 3'd0,
    3'd7, 3'd5, 3'd1, 3'd0,
    3'd6, 3'd4, 3'd3, 3'd2,
    3'd7, 3'd5, 3'd3, 3'd2
  };

  // Outcome of one lookup.
  typedef struct packed {
    logic hit;
    way_t way;
    logic wb;
  } sac_decision_t;

  // Counter update request for one access.
  typedef struct packed {
    logic en;
    logic is_write;
    logic hit;
    logic wb;
  } sac_count_t;

endpackage

FILE: sv/sac_lookup.sv
// ----------------------------------------------------------------------------
// sac_lookup: four-way tag compare and replacement choice
// Picks the lowest valid matching way, else the lowest invalid way, else
// the PLRU victim, and flags a dirty eviction.
// ----------------------------------------------------------------------------
module sac_lookup (
  input  sac_pkg::tag_t          tag,
  input  sac_pkg::way_mask_t     row_valid,
  input  sac_pkg::way_mask_t     row_dirty,
  input  sac_pkg::tag_row_t      row_tags,
  input  sac_pkg::plru_t         row_plru,
  output sac_pkg::sac_decision_t dec
);
  import sac_pkg::*;

  logic hit;
  way_t hit_way;
  logic found;
  way_t free_way;
  way_t fill_way;

  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    found    = 1'b0;
    free_way = '0;
    // scan high to low so the lowest way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_valid[w] && (row_tags[w] == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!row_valid[w]) begin
        found    = 1'b1;
        free_way = WAY_W'(w);
      end
    end
    fill_way = found ? free_way : PLRU_VICTIM[row_plru];
    dec.hit  = hit;
    dec.way  = hit ? hit_way : fill_way;
    dec.wb   = !hit && row_valid[fill_way] && row_dirty[fill_way];
  end

endmodule

FILE: sv/sac_store.sv
// ----------------------------------------------------------------------------
// sac_store: per-set line state
// Holds valid, dirty, tag and PLRU state per set; serves one set row and
// applies the fill, dirty mark and PLRU step of one access per cycle while upd_en is high.
// ----------------------------------------------------------------------------
module sac_store (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   upd_en,
  input  sac_pkg::idx_t          idx,
  input  sac_pkg::tag_t          tag,
  input  logic                   is_write,
  input  sac_pkg::sac_decision_t dec,
  output sac_pkg::way_mask_t     row_valid,
  output sac_pkg::way_mask_t     row_dirty,
  output sac_pkg::tag_row_t      row_tags,
  output sac_pkg::plru_t         row_plru
);
  import sac_pkg::*;

  way_mask_t valid_r [NUM_SETS];
  way_mask_t dirty_r [NUM_SETS];
  plru_t     plru_r  [NUM_SETS];
  tag_row_t  tags_r  [NUM_SETS];

  way_mask_t valid_nxt;
  way_mask_t dirty_nxt;
  plru_t     plru_nxt;

  assign row_valid = valid_r[idx];
  assign row_dirty = dirty_r[idx];
  assign row_tags  = tags_r[idx];
  assign row_plru  = plru_r[idx];

  always_comb begin
    valid_nxt = row_valid;
    dirty_nxt = row_dirty;
    if (!dec.hit) begin
      valid_nxt[dec.way] = 1'b1;
      dirty_nxt[dec.way] = 1'b0;
    end
    if (is_write) begin
      dirty_nxt[dec.way] = 1'b1;
    end
    plru_nxt = PLRU_NEXT[{row_plru, dec.way}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_r[s] <= '0;
        dirty_r[s] <= '0;
        plru_r[s]  <= '0;
      end
    end else if (upd_en) begin
      valid_r[idx] <= valid_nxt;
      dirty_r[idx] <= dirty_nxt;
      plru_r[idx]  <= plru_nxt;
    end
  end

  // tags are only read behind a valid bit
  always_ff @(posedge clk) begin
    if (upd_en && !dec.hit) begin
      tags_r[idx][dec.way] <= tag;
    end
  end

endmodule

FILE: sv/sac_counters.sv
// ----------------------------------------------------------------------------
// sac_counters: running access statistics
// Five wrapping counters: reads, writes, hits, misses, dirty evictions.
// ----------------------------------------------------------------------------
module sac_counters (
  input  logic                clk,
  input  logic                rst_n,
  input  sac_pkg::sac_count_t cnt,
  output sac_pkg::cnt_t       read_total,
  output sac_pkg::cnt_t       write_total,
  output sac_pkg::cnt_t       hit_total,
  output sac_pkg::cnt_t       miss_total,
  output sac_pkg::cnt_t       write_back_total
);
  import sac_pkg::*;

  cnt_t rd_r, wr_r, hit_r, miss_r, wb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r   <= '0;
      wr_r   <= '0;
      hit_r  <= '0;
      miss_r <= '0;
      wb_r   <= '0;
    end else if (cnt.en) begin
      if (cnt.is_write) wr_r <= wr_r + CNT_W'(1);
      else              rd_r <= rd_r + CNT_W'(1);
      if (cnt.hit)      hit_r  <= hit_r + CNT_W'(1);
      else              miss_r <= miss_r + CNT_W'(1);
      if (cnt.wb)       wb_r <= wb_r + CNT_W'(1);
    end
  end

  assign read_total       = rd_r;
  assign write_total      = wr_r;
  assign hit_total        = hit_r;
  assign miss_total       = miss_r;
  assign write_back_total = wb_r;

endmodule

FILE: sv/set_assoc_cache_tag_plru.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_plru: 4-way set-associative cache tag/PLRU controller
// Looks up each access in 16 sets x 4 ways, fills on a miss (first invalid
// way, else tree PLRU victim), tracks dirty lines and keeps access counts.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------
//  in      | in_valid / in_ready | in_address[15:0], in_mode
//  out     | out_valid/out_ready | out_hit, out_way, out_write_back,
//          |                     | out_{read,write,hit,miss,write_back}_total
//
//  One item per cycle sustained while out_ready is high; each access goes
//  from the input register through the lookup into the result register
//  before its result can be accepted.
//  All line state lives in flip-flops, so reset clears it with no sweep.
//  A stalled result holds the stage behind it; in_ready falls only when
//  both the input register and the result register are full and stalled.
//
module set_assoc_cache_tag_plru (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sac_pkg::addr_t in_address,
  input  logic           in_mode,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_hit,
  output sac_pkg::way_t  out_way,
  output logic           out_write_back,
  output sac_pkg::cnt_t  out_read_total,
  output sac_pkg::cnt_t  out_write_total,
  output sac_pkg::cnt_t  out_hit_total,
  output sac_pkg::cnt_t  out_miss_total,
  output sac_pkg::cnt_t  out_write_back_total
);
  import sac_pkg::*;

  // input register
  logic  stg_vld_r;
  addr_t stg_addr_r;
  logic  stg_mode_r;

  // result register (the counters double as the running-total fields)
  logic          out_vld_r;
  sac_decision_t res_r;

  logic          advance;
  idx_t          stg_idx;
  tag_t          stg_tag;
  way_mask_t     row_valid;
  way_mask_t     row_dirty;
  tag_row_t      row_tags;
  plru_t         row_plru;
  sac_decision_t dec;
  sac_count_t    cnt;

  // move the staged item into the result slot when that slot frees up
  assign advance  = stg_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !stg_vld_r || advance;

  assign stg_idx = stg_addr_r[OFF_W +: IDX_W];
  assign stg_tag = stg_addr_r[ADDR_BITS-1 -: TAG_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) stg_vld_r <= in_valid;
      if (advance)  out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
  end

  // payload registers: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_addr_r <= in_address;
      stg_mode_r <= in_mode;
    end
    if (advance) begin
      res_r <= dec;
    end
  end

  sac_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd_en    (advance),
    .idx       (stg_idx),
    .tag       (stg_tag),
    .is_write  (stg_mode_r),
    .dec       (dec),
    .row_valid (row_valid),
    .row_dirty (row_dirty),
    .row_tags  (row_tags),
    .row_plru  (row_plru)
  );

  sac_lookup u_lookup (
    .tag       (stg_tag),
    .row_valid (row_valid),
    .row_dirty (row_dirty),
    .row_tags  (row_tags),
    .row_plru  (row_plru),
    .dec       (dec)
  );

  // count on the same edge the result register loads
  assign cnt.en       = advance;
  assign cnt.is_write = stg_mode_r;
  assign cnt.hit      = dec.hit;
  assign cnt.wb       = dec.wb;

  sac_counters u_counters (
    .clk              (clk),
    .rst_n            (rst_n),
    .cnt              (cnt),
    .read_total       (out_read_total),
    .write_total      (out_write_total),
    .hit_total        (out_hit_total),
    .miss_total       (out_miss_total),
    .write_back_total (out_write_back_total)
  );

  assign out_valid      = out_vld_r;
  assign out_hit        = res_r.hit;
  assign out_way        = res_r.way;
  assign out_write_back = res_r.wb;

endmodule

FILE: sv/sac_checker.sv
// ----------------------------------------------------------------------------
// sac_checker: port-level checks of the cache tag controller
// Watches the result channel for stable stalls and consistent statistics.
// ----------------------------------------------------------------------------
module sac_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input logic           out_hit,
  input sac_pkg::way_t  out_way,
  input logic           out_write_back,
  input sac_pkg::cnt_t  out_read_total,
  input sac_pkg::cnt_t  out_write_total,
  input sac_pkg::cnt_t  out_hit_total,
  input sac_pkg::cnt_t  out_miss_total
);
  import sac_pkg::*;

  cnt_t acc_sum;
  cnt_t res_sum;

  assign acc_sum = out_read_total + out_write_total;
  assign res_sum = out_hit_total + out_miss_total;

  // a stalled result holds its way, hit flag and access count
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_way) && $stable(out_hit)
      && $stable(acc_sum))
    else $error("result changed while stalled");

  // every access is either a hit or a miss
  a_sum_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> acc_sum == res_sum)
    else $error("access count differs from hit plus miss count");

  // a hit never evicts
  a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_write_back)
    else $error("write-back reported on a hit");

  // consecutive results are one access apart
  a_step_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid || acc_sum == $past(acc_sum) + CNT_W'(1))
    else $error("access count skipped or repeated");

endmodule

bind set_assoc_cache_tag_plru sac_checker u_sac_checker (.*);
